// ----- rtl/core/rbp_pkg.sv -----
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the ring buffer pool
// Command codes, fixed field widths and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

    localparam int CMD_W     = 3;
    localparam int ID_IN_W   = 2;
    localparam int DATA_W    = 8;
    localparam int FILL_W    = 8;
    localparam int MASK_W    = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 3'd5;

    // Status of one request, everything but the popped byte.
    typedef struct packed {
        logic                ok;
        logic [ID_IN_W-1:0]  id_out;
        logic [FILL_W-1:0]   fill_level;
        logic                is_empty;
        logic                is_full;
        logic [MASK_W-1:0]   used_mask;
        logic                pop;
    } rbp_result_t;

    // Byte store strobes.
    typedef struct packed {
        logic we;
        logic re;
    } rbp_mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/rbp_ram.sv -----
// ----------------------------------------------------------------------------
// rbp_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbp_ctrl: buffer bookkeeping of the ring buffer pool
// Holds the in-use and prepared bitmaps, head and count per buffer, decodes
// one request per cycle while take is high, and drives the byte store.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ctrl import rbp_pkg::*; #(
    parameter int NUM_BUFFERS  = 4,
    parameter int BUFFER_BYTES = 128,
    localparam int ID_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1,
    localparam int POS_W = $clog2(BUFFER_BYTES),
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               take,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [ID_IN_W-1:0] buf_id,
    input  wire logic [DATA_W-1:0]  data_in,
    output rbp_result_t             res,
    output rbp_mem_ctl_t            mem,
    output logic [ID_W+POS_W-1:0]   mem_addr,
    output logic [DATA_W-1:0]       mem_wdata
);

    logic [NUM_BUFFERS-1:0] in_use_reg,   in_use_next;
    logic [NUM_BUFFERS-1:0] prepared_reg, prepared_next;
    logic [POS_W-1:0]       head_reg  [NUM_BUFFERS];
    logic [POS_W-1:0]       head_next [NUM_BUFFERS];
    logic [CNT_W-1:0]       count_reg [NUM_BUFFERS];
    logic [CNT_W-1:0]       count_next[NUM_BUFFERS];

    logic             valid_id;
    logic [ID_W-1:0]  id_sel;
    logic             free_found;
    logic [ID_W-1:0]  free_idx;
    logic             is_alloc;
    logic [ID_W-1:0]  tgt;
    logic             tgt_valid;
    logic [CNT_W-1:0] cur_cnt;
    logic [POS_W-1:0] cur_head;
    logic             cur_prep;
    logic             cur_full;
    logic [POS_W:0]   push_sum;
    logic [POS_W-1:0] push_pos;
    logic [POS_W-1:0] head_inc;
    logic [CNT_W-1:0] cnt_new;
    logic             prep_new;
    logic             ok;
    logic             do_we;
    logic             do_re;
    logic [POS_W-1:0] addr_pos;
    logic [CNT_W-1:0] fill;

    // Lowest free buffer.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = ID_W'(i);
            end
        end
    end

    assign valid_id  = int'(buf_id) < NUM_BUFFERS;
    assign id_sel    = valid_id ? ID_W'(buf_id) : '0;
    assign is_alloc  = (cmd == CMD_ALLOC);
    assign tgt       = is_alloc ? free_idx : id_sel;
    assign tgt_valid = is_alloc ? free_found : valid_id;

    assign cur_cnt  = count_reg[tgt];
    assign cur_head = head_reg[tgt];
    assign cur_prep = prepared_reg[tgt];
    assign cur_full = (cur_cnt == CNT_W'(BUFFER_BYTES));

    // Tail slot: head plus count, wrapped once.
    assign push_sum = {1'b0, cur_head} + (POS_W+1)'(cur_cnt);
    assign push_pos = (push_sum >= (POS_W+1)'(BUFFER_BYTES))
                    ? POS_W'(push_sum - (POS_W+1)'(BUFFER_BYTES))
                    : POS_W'(push_sum);
    assign head_inc = (cur_head == POS_W'(BUFFER_BYTES - 1)) ? '0 : cur_head + 1'b1;

    always_comb begin
        in_use_next   = in_use_reg;
        prepared_next = prepared_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        ok            = 1'b1;
        cnt_new       = cur_cnt;
        prep_new      = cur_prep;
        do_we         = 1'b0;
        do_re         = 1'b0;
        addr_pos      = cur_head;
        case (cmd)
            CMD_ALLOC: begin
                ok = free_found;
                if (free_found) begin
                    in_use_next[tgt]   = 1'b1;
                    prepared_next[tgt] = 1'b1;
                    head_next[tgt]     = '0;
                    count_next[tgt]    = '0;
                    cnt_new            = '0;
                    prep_new           = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (valid_id) begin
                    in_use_next[tgt] = 1'b0;
                end
            end
            CMD_CLEAR: begin
                if (valid_id) begin
                    prepared_next[tgt] = 1'b1;
                    head_next[tgt]     = '0;
                    count_next[tgt]    = '0;
                    cnt_new            = '0;
                    prep_new           = 1'b1;
                end
            end
            CMD_PUSH: begin
                ok = valid_id && cur_prep && !cur_full;
                if (ok) begin
                    count_next[tgt] = cur_cnt + 1'b1;
                    cnt_new         = cur_cnt + 1'b1;
                    do_we           = 1'b1;
                    addr_pos        = push_pos;
                end
            end
            CMD_POP: begin
                ok = valid_id && (cur_cnt != '0);
                if (ok) begin
                    count_next[tgt] = cur_cnt - 1'b1;
                    cnt_new         = cur_cnt - 1'b1;
                    head_next[tgt]  = head_inc;
                    do_re           = 1'b1;
                end
            end
            CMD_FREE_ALL: begin
                in_use_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign fill = tgt_valid ? cnt_new : '0;

    always_comb begin
        res.ok         = ok;
        res.id_out     = is_alloc ? (free_found ? ID_IN_W'(free_idx) : '0) : buf_id;
        res.fill_level = FILL_W'(fill);
        res.is_empty   = (fill == '0);
        res.is_full    = tgt_valid && prep_new && (cnt_new == CNT_W'(BUFFER_BYTES));
        res.used_mask  = MASK_W'(in_use_next);
        res.pop        = do_re;
    end

    assign mem.we    = take & do_we;
    assign mem.re    = take & do_re;
    assign mem_addr  = {tgt, addr_pos};
    assign mem_wdata = data_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg   <= '0;
            prepared_reg <= '0;
            head_reg     <= '{default: '0};
            count_reg    <= '{default: '0};
        end else if (take) begin
            in_use_reg   <= in_use_next;
            prepared_reg <= prepared_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[tgt] <= CNT_W'(BUFFER_BYTES))
        else $error("buffer count above capacity");

    a_free_all: assert property (@(posedge aclk) disable iff (!aresetn)
        take && cmd == CMD_FREE_ALL |=> in_use_reg == '0)
        else $error("free all left a buffer in use");

    a_alloc_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        take && is_alloc && free_found |=>
            in_use_reg[$past(free_idx)] && prepared_reg[$past(free_idx)] &&
            count_reg[$past(free_idx)] == '0)
        else $error("allocated buffer not marked, prepared and empty");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && mem.we |=> count_reg[$past(tgt)] == $past(cur_cnt) + 1'b1)
        else $error("store write without count increment");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ring_buffer_pool.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_pool: pool of byte ring buffers with an in-use bitmap
// Takes one allocate, release, clear, push, pop or free-all request per
// cycle while its results are taken, and returns one status result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Bits used  Contents
//  s_axis    in         13 of 16   cmd, buf_id, data_in
//  m_axis    out        25 of 32   ok, id_out, data_out, fill_level,
//                                  is_empty, is_full, used_mask
//
// A request updates the buffer state at the accepting edge, and the result
// register loads at the same edge. One request per cycle is sustained while
// results are taken; the single port of the byte store is enough since a
// request either writes one byte or reads one byte, never both. The popped
// byte arrives from the store's registered read port together with the result.
// Reset clears the bitmaps, heads and counts at once; the byte store is not
// cleared, as no request can read a byte before it is written.
// When the result is stalled, s_tready falls and the store read data holds.
//
`default_nettype none

module ring_buffer_pool import rbp_pkg::*; #(
    parameter int NUM_BUFFERS  = 4,
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // [2:0] cmd, [4:3] buf_id, [12:5] data_in, [15:13] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] ok, [2:1] id_out, [10:3] data_out, [18:11] fill_level,
    // [19] is_empty, [20] is_full, [24:21] used_mask, [31:25] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    localparam int ID_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int POS_W     = $clog2(BUFFER_BYTES);
    localparam int RAM_DEPTH = NUM_BUFFERS * (2 ** POS_W);
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic                  take;
    rbp_result_t           res;
    rbp_mem_ctl_t          mem;
    logic [ID_W+POS_W-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]     data_out;

    rbp_result_t res_reg;
    logic        m_valid_reg;

    // The result register parts the two sides: a new request enters whenever
    // the held result is taken in the same cycle or none is held.
    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    rbp_ctrl #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .cmd       (s_tdata[2:0]),
        .buf_id    (s_tdata[4:3]),
        .data_in   (s_tdata[12:5]),
        .res       (res),
        .mem       (mem),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    // Buffer b owns the slots whose upper address bits equal b.
    rbp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem.we),
        .re    (mem.re),
        .addr  (mem_addr[RAM_AW-1:0]),
        .wdata (mem_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
        end
    end

    // Store read data is only meaningful for a successful pop.
    assign data_out = res_reg.pop ? ram_rdata : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, res_reg.used_mask, res_reg.is_full, res_reg.is_empty,
                       res_reg.fill_level, data_out, res_reg.id_out, res_reg.ok};

endmodule

`default_nettype wire
